@@ hw/rtl/shpp_pkg.sv @@
package shpp_pkg;

	localparam int PAYLOAD_BYTES = 9;
	localparam int POS_W = $clog2(PAYLOAD_BYTES + 1);
	localparam int IDX_W = $clog2(PAYLOAD_BYTES);

	localparam logic [7:0] CRC_POLY = 8'h07;

	localparam logic [7:0] SYNC_FIRST_RST = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

	localparam int CFG_INDEX_W = 4;
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND = CFG_INDEX_W'(1);

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_GOOD = 2'd1,
		ST_CRC_FAIL = 2'd2,
		ST_SYNC_LOST = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'b001,
		PH_SECOND = 3'b010,
		PH_COLLECT = 3'b100
	} phase_t;

	typedef struct packed {
		status_t status;
		logic [7:0] seq_number;
		logic [7:0] command_code;
		logic [7:0] speed_percent;
		logic [7:0] event_code;
		logic [7:0] flag_bits;
		logic [15:0] zone_distance;
		logic [15:0] closing_speed;
		logic [31:0] good_count;
		logic [31:0] crc_fail_count;
		logic [31:0] sync_loss_count;
	} result_t;

	function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/sync_header_packet_parser_crc8.sv @@
// Pipeline: a request is registered at the input, handled combinationally and its result
// is registered at the output, where it is offered until taken; a pending result stalls
// the input register. Throughput: one byte per cycle while results are taken; the input
// and output registers decouple the two sides.
// Reset (arst_n low, asynchronous) returns the parser to header hunting, clears the
// counters and the running CRC and restores the header bytes to 0xAA and 0x55.
module sync_header_packet_parser_crc8
	import shpp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             rx_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic [7:0]             seq_number,
	output logic [7:0]             command_code,
	output logic [7:0]             speed_percent,
	output logic [7:0]             event_code,
	output logic [7:0]             flag_bits,
	output logic [15:0]            zone_distance,
	output logic signed [15:0]     closing_speed,
	output logic [31:0]            good_count,
	output logic [31:0]            crc_fail_count,
	output logic [31:0]            sync_loss_count
);

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;
	logic valid_s1;
	logic [7:0] rx_byte_s1;
	logic valid_s2;
	result_t res_s2;
	result_t res;
	logic out_free;
	logic step;

	assign out_free = !valid_s2 || out_ready;
	assign step = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_FIRST: sync_first_q <= cfg_data;
				REG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	shpp_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.byte_in     (rx_byte_s1),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.res         (res)
	);

	assign out_valid = valid_s2;
	assign status = res_s2.status;
	assign seq_number = res_s2.seq_number;
	assign command_code = res_s2.command_code;
	assign speed_percent = res_s2.speed_percent;
	assign event_code = res_s2.event_code;
	assign flag_bits = res_s2.flag_bits;
	assign zone_distance = res_s2.zone_distance;
	assign closing_speed = $signed(res_s2.closing_speed);
	assign good_count = res_s2.good_count;
	assign crc_fail_count = res_s2.crc_fail_count;
	assign sync_loss_count = res_s2.sync_loss_count;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(res_s2))
		else $error("pending result overwritten before it was taken");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(rx_byte_s1))
		else $error("held input byte lost");

	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("handled byte produced no result");

endmodule

@@ hw/rtl/shpp_frame.sv @@
module shpp_frame
	import shpp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_in,
	input  logic [7:0]  sync_first,
	input  logic [7:0]  sync_second,
	output result_t     res
);

	phase_t phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0] crc_q, crc_d;
	logic [31:0] good_q, good_d;
	logic [31:0] crc_fail_q, crc_fail_d;
	logic [31:0] sync_loss_q, sync_loss_d;
	logic [7:0] store_q [PAYLOAD_BYTES];
	logic store_we;
	status_t status;

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		crc_d = crc_q;
		good_d = good_q;
		crc_fail_d = crc_fail_q;
		sync_loss_d = sync_loss_q;
		store_we = 1'b0;
		status = ST_NONE;
		unique case (phase_q)
			PH_HUNT: begin
				if (byte_in == sync_first) begin
					phase_d = PH_SECOND;
				end
			end
			PH_SECOND: begin
				if (byte_in == sync_second) begin
					phase_d = PH_COLLECT;
					pos_d = '0;
					crc_d = '0;
				end else begin
					phase_d = (byte_in == sync_first) ? PH_SECOND : PH_HUNT;
					sync_loss_d = sync_loss_q + 32'd1;
					status = ST_SYNC_LOST;
				end
			end
			PH_COLLECT: begin
				if (pos_q < POS_W'(PAYLOAD_BYTES)) begin
					store_we = 1'b1;
					crc_d = crc8_fold(crc_q, byte_in);
					pos_d = pos_q + POS_W'(1);
				end else begin
					phase_d = PH_HUNT;
					pos_d = '0;
					crc_d = '0;
					if (byte_in != crc_q) begin
						crc_fail_d = crc_fail_q + 32'd1;
						status = ST_CRC_FAIL;
					end else begin
						good_d = good_q + 32'd1;
						status = ST_GOOD;
					end
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q <= '0;
			crc_q <= '0;
			good_q <= '0;
			crc_fail_q <= '0;
			sync_loss_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			crc_q <= crc_d;
			good_q <= good_d;
			crc_fail_q <= crc_fail_d;
			sync_loss_q <= sync_loss_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && store_we) begin
			store_q[pos_q[IDX_W-1:0]] <= byte_in;
		end
	end

	always_comb begin
		res = '0;
		res.status = status;
		res.good_count = good_d;
		res.crc_fail_count = crc_fail_d;
		res.sync_loss_count = sync_loss_d;
		if (status == ST_GOOD) begin
			res.seq_number = store_q[0];
			res.command_code = store_q[1];
			res.speed_percent = store_q[2];
			res.event_code = store_q[3];
			res.flag_bits = store_q[4];
			res.zone_distance = {store_q[6], store_q[5]};
			res.closing_speed = {store_q[8], store_q[7]};
		end
	end

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(PAYLOAD_BYTES))
		else $error("byte position beyond the payload length");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_COLLECT |-> (pos_q == '0 && crc_q == '0))
		else $error("position or CRC not cleared outside a frame");

	a_good_count: assert property (@(posedge clk) disable iff (!arst_n)
		step && status == ST_GOOD |=> good_q == $past(good_q) + 32'd1)
		else $error("good packet counter did not advance");

	a_loss_phase: assert property (@(posedge clk) disable iff (!arst_n)
		step && status == ST_SYNC_LOST |=> phase_q != PH_COLLECT)
		else $error("sync loss entered the collect phase");

endmodule

@@ verif/shpp_status_checker.sv @@
module shpp_status_checker
	import shpp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [7:0]             rx_byte,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [1:0]             status,
	input  logic [7:0]             seq_number,
	input  logic [7:0]             command_code,
	input  logic [7:0]             speed_percent,
	input  logic [7:0]             event_code,
	input  logic [7:0]             flag_bits,
	input  logic [15:0]            zone_distance,
	input  logic signed [15:0]     closing_speed,
	input  logic [31:0]            good_count,
	input  logic [31:0]            crc_fail_count,
	input  logic [31:0]            sync_loss_count,
	output int unsigned            outstanding,
	output int unsigned            fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0] hdr_first;
	logic [7:0] hdr_second;
	phase_t frame_phase;
	int unsigned frame_pos;
	logic [7:0] frame_bytes [PAYLOAD_BYTES];
	logic [7:0] frame_crc;
	logic [31:0] good_tot;
	logic [31:0] crc_bad_tot;
	logic [31:0] sync_lost_tot;
	result_t status_queue [$];
	int unsigned mismatch_total = 0;

	assign fail_count = mismatch_total;

	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		logic fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ data[i];
			c = {c[6:0], 1'b0};
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function automatic result_t predict_status(input logic [7:0] b);
		result_t r;
		r = '0;
		r.status = ST_NONE;
		case (frame_phase)
			PH_HUNT: begin
				if (b == hdr_first)
					frame_phase = PH_SECOND;
			end
			PH_SECOND: begin
				if (b == hdr_second) begin
					frame_phase = PH_COLLECT;
					frame_pos = 0;
					frame_crc = 8'h00;
				end else begin
					frame_phase = (b == hdr_first) ? PH_SECOND : PH_HUNT;
					sync_lost_tot = sync_lost_tot + 32'd1;
					r.status = ST_SYNC_LOST;
				end
			end
			default: begin
				if (frame_pos < PAYLOAD_BYTES) begin
					frame_bytes[frame_pos] = b;
					frame_crc = crc_step(frame_crc, b);
					frame_pos++;
				end else begin
					frame_phase = PH_HUNT;
					frame_pos = 0;
					if (b != frame_crc) begin
						crc_bad_tot = crc_bad_tot + 32'd1;
						r.status = ST_CRC_FAIL;
					end else begin
						good_tot = good_tot + 32'd1;
						r.status = ST_GOOD;
						r.seq_number = frame_bytes[0];
						r.command_code = frame_bytes[1];
						r.speed_percent = frame_bytes[2];
						r.event_code = frame_bytes[3];
						r.flag_bits = frame_bytes[4];
						r.zone_distance = {frame_bytes[6], frame_bytes[5]};
						r.closing_speed = {frame_bytes[8], frame_bytes[7]};
					end
					frame_crc = 8'h00;
				end
			end
		endcase
		r.good_count = good_tot;
		r.crc_fail_count = crc_bad_tot;
		r.sync_loss_count = sync_lost_tot;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			mismatch_total++;
			if (mismatch_total <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp, act);
		end
	endtask

	task automatic check_result();
		result_t e;
		if (status_queue.size() == 0) begin
			mismatch_total++;
			if (mismatch_total <= 10)
				$display("%0t: result with no request outstanding, status %0d", $realtime, status);
		end else begin
			e = status_queue.pop_front();
			check_field("status", e.status, status);
			check_field("seq_number", e.seq_number, seq_number);
			check_field("command_code", e.command_code, command_code);
			check_field("speed_percent", e.speed_percent, speed_percent);
			check_field("event_code", e.event_code, event_code);
			check_field("flag_bits", e.flag_bits, flag_bits);
			check_field("zone_distance", e.zone_distance, zone_distance);
			check_field("closing_speed", e.closing_speed, $unsigned(closing_speed));
			check_field("good_count", e.good_count, good_count);
			check_field("crc_fail_count", e.crc_fail_count, crc_fail_count);
			check_field("sync_loss_count", e.sync_loss_count, sync_loss_count);
		end
	endtask

	// Each accepted request is predicted at once; results are matched in order of arrival.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first = SYNC_FIRST_RST;
			hdr_second = SYNC_SECOND_RST;
			frame_phase = PH_HUNT;
			frame_pos = 0;
			foreach (frame_bytes[i])
				frame_bytes[i] = 8'h00;
			frame_crc = 8'h00;
			good_tot = '0;
			crc_bad_tot = '0;
			sync_lost_tot = '0;
			status_queue.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_SYNC_FIRST)
					hdr_first = cfg_data;
				else if (cfg_index == REG_SYNC_SECOND)
					hdr_second = cfg_data;
			end
			if (in_valid && in_ready)
				status_queue.push_back(predict_status(rx_byte));
			if (out_valid && out_ready)
				check_result();
			outstanding <= status_queue.size();
		end
	end

endmodule

@@ verif/tb_sync_header_packet_parser_crc8.sv @@
module tb_sync_header_packet_parser_crc8 import shpp_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_SYNC_FIRST;
	logic [7:0] cfg_data = 8'h00;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [7:0] seq_number;
	logic [7:0] command_code;
	logic [7:0] speed_percent;
	logic [7:0] event_code;
	logic [7:0] flag_bits;
	logic [15:0] zone_distance;
	logic signed [15:0] closing_speed;
	logic [31:0] good_count;
	logic [31:0] crc_fail_count;
	logic [31:0] sync_loss_count;

	int unsigned outstanding;
	int unsigned fail_count;
	int unsigned bytes_sent = 0;
	bit in_quiet = 1'b0;
	bit out_quiet = 1'b0;
	logic [7:0] cur_first = SYNC_FIRST_RST;
	logic [7:0] cur_second = SYNC_SECOND_RST;

	sync_header_packet_parser_crc8 DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.seq_number(seq_number),
		.command_code(command_code),
		.speed_percent(speed_percent),
		.event_code(event_code),
		.flag_bits(flag_bits),
		.zone_distance(zone_distance),
		.closing_speed(closing_speed),
		.good_count(good_count),
		.crc_fail_count(crc_fail_count),
		.sync_loss_count(sync_loss_count)
	);

	shpp_status_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.seq_number(seq_number),
		.command_code(command_code),
		.speed_percent(speed_percent),
		.event_code(event_code),
		.flag_bits(flag_bits),
		.zone_distance(zone_distance),
		.closing_speed(closing_speed),
		.good_count(good_count),
		.crc_fail_count(crc_fail_count),
		.sync_loss_count(sync_loss_count),
		.outstanding(outstanding),
		.fail_count(fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int unsigned idle_len(input bit quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [7:0] crc8_msb(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		repeat (8)
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		return c;
	endfunction

	function automatic logic [7:0] payload_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return cur_first;
			3: return cur_second;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int unsigned hold = 0;
		forever begin
			@(posedge clk);
			if (hold != 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
				hold = idle_len(out_quiet);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = idle_len(in_quiet);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_payload(input logic [7:0] body [PAYLOAD_BYTES], input bit spoil);
		logic [7:0] crc;
		crc = 8'h00;
		foreach (body[i]) begin
			crc = crc8_msb(crc, body[i]);
			send_byte(body[i]);
		end
		if (spoil)
			crc = crc ^ 8'($urandom_range(1, 255));
		send_byte(crc);
	endtask

	task automatic send_frame(input logic [7:0] body [PAYLOAD_BYTES], input bit spoil);
		send_byte(cur_first);
		send_byte(cur_second);
		send_payload(body, spoil);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_headers(input logic [7:0] first, input logic [7:0] second);
		wait_idle();
		write_reg(REG_SYNC_FIRST, first);
		write_reg(REG_SYNC_SECOND, second);
		write_reg(REG_SYNC_SECOND + CFG_INDEX_W'($urandom_range(1, 14)),
			8'($urandom_range(0, 255)));
		cfg_we <= 1'b0;
		cur_first = first;
		cur_second = second;
		in_quiet = ($urandom_range(0, 3) == 0);
		out_quiet = ($urandom_range(0, 3) == 0);
	endtask

	task automatic random_traffic(input int unsigned upto);
		logic [7:0] body [PAYLOAD_BYTES];
		int unsigned pick;
		while (bytes_sent < upto) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				foreach (body[i])
					body[i] = payload_byte();
				send_frame(body, $urandom_range(0, 6) == 0);
			end else if (pick < 82) begin
				send_byte(cur_first);
				send_byte($urandom_range(0, 1) ? cur_first : 8'($urandom_range(0, 255)));
			end else if (pick < 87) begin
				send_byte(cur_first);
				send_byte(cur_second);
				repeat ($urandom_range(1, PAYLOAD_BYTES - 1))
					send_byte(payload_byte());
			end else begin
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		logic [7:0] body [PAYLOAD_BYTES];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'hAA);
		send_byte(8'h12);
		send_byte(8'hAA);
		send_byte(8'hAA);
		send_byte(8'h55);
		body = '{8'hAA, 8'h55, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h80};
		send_payload(body, 1'b0);
		body = '{8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h7F};
		send_frame(body, 1'b1);

		random_traffic(bytes_sent + 230);
		set_headers(8'h00, 8'hFF);
		random_traffic(bytes_sent + 255);
		set_headers(8'hFF, 8'h00);
		random_traffic(bytes_sent + 255);
		set_headers(8'h3C, 8'h3C);
		random_traffic(bytes_sent + 255);
		set_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		random_traffic(bytes_sent + 255);
		set_headers(SYNC_FIRST_RST, SYNC_SECOND_RST);
		random_traffic(bytes_sent + 255);

		wait_idle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/shpp_pkg.sv
hw/rtl/shpp_frame.sv
hw/rtl/sync_header_packet_parser_crc8.sv
verif/shpp_status_checker.sv
verif/tb_sync_header_packet_parser_crc8.sv
